// ----- rtl/core/eslc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_pkg
// shared widths, command and status codes and the walk result type
// ----------------------------------------------------------------------------
package eslc_pkg;

  localparam int MAX_SLOTS_DEF = 256;

  localparam int CMD_W    = 2;
  localparam int START_W  = 32;
  localparam int TICK_W   = 33;
  localparam int STATUS_W = 4;
  localparam int PORT_W   = 16;
  localparam int SLOT_W   = 9;
  localparam int HCL_W    = 32;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 64;

  // item commands
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RSV  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FREE_SHORT   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_UNSORT  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_UNMERGE = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_BORDER  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_RSV_SHORT    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_RSV_UNSORT   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_RSV_BORDER   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOT_INVERSE  = 4'd8;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL    = 4'd9;

  typedef struct packed {
    logic              valid;
    logic              fail;
    logic [TICK_W-1:0] tick;
  } walk_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/eslc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module eslc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/eslc_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_walk
// two-cursor walk over the stored free and reserved lists, one step a cycle
// ----------------------------------------------------------------------------
module eslc_walk #(
  parameter int MAX_SLOTS = eslc_pkg::MAX_SLOTS_DEF,
  localparam int CW = $clog2(MAX_SLOTS + 1),
  localparam int AW = $clog2(MAX_SLOTS)
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       start,
  input  wire logic                                       ack,
  input  wire logic [eslc_pkg::HCL_W-1:0]                 hcl,
  input  wire logic [CW-1:0]                              free_count,
  input  wire logic [CW-1:0]                              rsv_count,
  input  wire logic [2*eslc_pkg::START_W-1:0]             free_rdata,
  input  wire logic [eslc_pkg::START_W+eslc_pkg::TICK_W-1:0] rsv_rdata,
  output logic      [AW-1:0]                              free_raddr,
  output logic      [AW-1:0]                              rsv_raddr,
  output eslc_pkg::walk_res_t                             res
);

  import eslc_pkg::*;

  typedef enum logic [1:0] {W_IDLE, W_STEP, W_DONE} state_t;

  state_t            state;
  logic [TICK_W-1:0] tick;
  logic              fail;
  logic [CW-1:0]     fc;
  logic [CW-1:0]     rc;
  logic [CW-1:0]     fc_next;
  logic [CW-1:0]     rc_next;
  logic              at_border;
  logic              free_hit;
  logic              rsv_hit;

  assign at_border = tick == {1'b0, hcl};
  assign free_hit  = (fc < free_count) && ({1'b0, free_rdata[START_W-1:0]} == tick);
  assign rsv_hit   = (rc < rsv_count) && ({1'b0, rsv_rdata[START_W-1:0]} == tick);

  // read addresses follow the next cursor so data lines up with the cursor
  always_comb begin
    fc_next = fc;
    rc_next = rc;
    if (start) begin
      fc_next = '0;
      rc_next = '0;
    end else if (state == W_STEP && !at_border) begin
      if (free_hit) begin
        fc_next = fc + CW'(1);
      end else if (rsv_hit) begin
        rc_next = rc + CW'(1);
      end
    end
  end

  assign free_raddr = fc_next[AW-1:0];
  assign rsv_raddr  = rc_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      fc    <= '0;
      rc    <= '0;
      fail  <= 1'b0;
      tick  <= '0;
    end else begin
      fc <= fc_next;
      rc <= rc_next;
      case (state)
        W_IDLE: begin
          if (start) begin
            tick  <= '0;
            fail  <= 1'b0;
            state <= W_STEP;
          end
        end
        W_STEP: begin
          if (at_border) begin
            state <= W_DONE;
          end else if (free_hit) begin
            tick <= {1'b0, free_rdata[2*START_W-1:START_W]} + TICK_W'(1);
          end else if (rsv_hit) begin
            tick <= rsv_rdata[START_W+TICK_W-1:START_W];
          end else begin
            fail  <= 1'b1;
            state <= W_DONE;
          end
        end
        W_DONE: begin
          if (ack) begin
            state <= W_IDLE;
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

  assign res.valid = (state == W_DONE);
  assign res.fail  = fail;
  assign res.tick  = tick;

endmodule
`default_nettype wire

// ----- rtl/core/egress_slot_list_checker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// egress_slot_list_checker_core
// checks the free and reserved slot lists of one egress port at a time
// ----------------------------------------------------------------------------
// usage
//   s_* carries slot items: tuser is the command (free slot, reserved slot,
//   end of port), tdata holds start tick and bound tick. every item gives
//   exactly one result item on m_*; m_tlast marks the result of an end of
//   port item, which carries the verdict for the whole port.
//   cfg_we/cfg_wdata write the hyper cycle length (reset value 1); write it
//   only while no item is in flight.
//   flow: a slot item is taken into an input register; once the output
//   register is free it is checked and stored as its result is loaded onto
//   m_*. the input register takes no new item until the held one has left.
//   an end of port item of a clean port runs the walk, one step a cycle
//   over the stored slots, and its result follows when the walk is done.
//   reset clears counts, the error latch and the port number; the slot
//   memories need no clearing since only entries below the counts are read.
//   a stalled m_tready holds the result; one more item is taken into the
//   input register meanwhile, after which s_tready drops.
// ----------------------------------------------------------------------------
module egress_slot_list_checker_core #(
  parameter int MAX_SLOTS = eslc_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [eslc_pkg::HCL_W-1:0]      cfg_wdata,
  // slot items in
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [eslc_pkg::S_DATA_W-1:0]   s_tdata,   // start_tick, bound_tick
  input  wire logic [eslc_pkg::CMD_W-1:0]      s_tuser,   // command
  // results out
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [eslc_pkg::M_DATA_W-1:0]   m_tdata,   // status, port_number,
                                                          // failing_slot, failing_tick
  output logic                                 m_tlast    // port_done
);

  import eslc_pkg::*;

  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int FW    = 2 * START_W;
  localparam int RW    = START_W + TICK_W;

  // configuration register
  logic [HCL_W-1:0]    hcl;

  // input register
  logic                pend_valid;
  logic [CMD_W-1:0]    pend_cmd;
  logic [START_W-1:0]  pend_start;
  logic [TICK_W-1:0]   pend_bound;

  // per port state
  logic [CW-1:0]       free_count;
  logic [CW-1:0]       rsv_count;
  logic [TICK_W-1:0]   free_na;
  logic [TICK_W-1:0]   rsv_na;
  logic [PORT_W-1:0]   cur_port;
  logic [STATUS_W-1:0] lat_err;
  logic [SLOT_W-1:0]   lat_slot;
  logic [TICK_W-1:0]   lat_tick;
  logic                walking;

  // output register
  logic [STATUS_W-1:0] out_status;
  logic [PORT_W-1:0]   out_port;
  logic [SLOT_W-1:0]   out_slot;
  logic [TICK_W-1:0]   out_tick;

  // datapath
  logic [STATUS_W-1:0] err_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [TICK_W-1:0]   tick_next;
  logic                out_free;
  logic                pend_take;
  logic                out_load;
  logic                out_done;
  logic                walk_start;
  logic                walk_ack;
  logic                free_we;
  logic                rsv_we;
  logic [TICK_W-1:0]   start_ext;
  logic [CW+SLOT_W-1:0] fc_ext;
  logic [CW+SLOT_W-1:0] rc_ext;
  logic [SLOT_W-1:0]   fc_slot;
  logic [SLOT_W-1:0]   rc_slot;
  logic                free_full;
  logic                rsv_full;
  logic [TICK_W-1:0]   hcl_ext;

  // memories and walker
  logic [AW-1:0]       free_raddr;
  logic [AW-1:0]       rsv_raddr;
  logic [FW-1:0]       free_rdata;
  logic [RW-1:0]       rsv_rdata;
  walk_res_t           walk_res;

  assign s_tready  = !pend_valid;
  assign out_free  = !m_tvalid || m_tready;
  assign pend_take = pend_valid && !walking && out_free;

  assign start_ext = {1'b0, pend_start};
  assign hcl_ext   = {1'b0, hcl};
  // slot index as reported, modulo 512
  assign fc_ext    = {{SLOT_W{1'b0}}, free_count};
  assign rc_ext    = {{SLOT_W{1'b0}}, rsv_count};
  assign fc_slot   = fc_ext[SLOT_W-1:0];
  assign rc_slot   = rc_ext[SLOT_W-1:0];
  assign free_full = free_count == CW'(MAX_SLOTS);
  assign rsv_full  = rsv_count == CW'(MAX_SLOTS);

  // checks on arrival, end of port dispatch and walk completion
  always_comb begin
    err_next   = lat_err;
    slot_next  = lat_slot;
    tick_next  = lat_tick;
    out_load   = 1'b0;
    out_done   = 1'b0;
    walk_start = 1'b0;
    walk_ack   = 1'b0;
    free_we    = 1'b0;
    rsv_we     = 1'b0;
    if (walking) begin
      if (walk_res.valid && out_free) begin
        out_load = 1'b1;
        out_done = 1'b1;
        walk_ack = 1'b1;
        if (walk_res.fail) begin
          err_next  = ST_NOT_INVERSE;
          slot_next = '0;
          tick_next = walk_res.tick;
        end
      end
    end else if (pend_take) begin
      case (pend_cmd)
        CMD_FREE: begin
          out_load = 1'b1;
          if (lat_err == ST_OK) begin
            slot_next = fc_slot;
            if (start_ext > pend_bound) begin
              err_next  = ST_FREE_SHORT;
              tick_next = start_ext;
            end else if (start_ext < free_na) begin
              err_next  = ST_FREE_UNSORT;
              tick_next = start_ext;
            end else if (start_ext == free_na && free_na != '0) begin
              // touching the previous free slot, should have been merged
              err_next  = ST_FREE_UNMERGE;
              tick_next = start_ext;
            end else if (pend_bound >= hcl_ext) begin
              err_next  = ST_FREE_BORDER;
              tick_next = pend_bound;
            end else if (free_full) begin
              err_next  = ST_LIST_FULL;
              tick_next = start_ext;
            end else begin
              // a clean slot leaves the latch untouched
              slot_next = lat_slot;
              free_we   = 1'b1;
            end
          end
        end
        CMD_RSV: begin
          out_load = 1'b1;
          if (lat_err == ST_OK) begin
            slot_next = rc_slot;
            if (start_ext >= pend_bound) begin
              err_next  = ST_RSV_SHORT;
              tick_next = start_ext;
            end else if (start_ext < rsv_na) begin
              err_next  = ST_RSV_UNSORT;
              tick_next = start_ext;
            end else if (pend_bound > hcl_ext) begin
              err_next  = ST_RSV_BORDER;
              tick_next = pend_bound - TICK_W'(1);
            end else if (rsv_full) begin
              err_next  = ST_LIST_FULL;
              tick_next = start_ext;
            end else begin
              // a clean slot leaves the latch untouched
              slot_next = lat_slot;
              rsv_we    = 1'b1;
            end
          end
        end
        CMD_END: begin
          if (lat_err == ST_OK) begin
            walk_start = 1'b1;
          end else begin
            out_load = 1'b1;
            out_done = 1'b1;
          end
        end
        default: begin
          // unknown command: report the latch, change nothing
          out_load = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcl        <= HCL_W'(1);
      pend_valid <= 1'b0;
      free_count <= '0;
      rsv_count  <= '0;
      free_na    <= '0;
      rsv_na     <= '0;
      cur_port   <= '0;
      lat_err    <= ST_OK;
      lat_slot   <= '0;
      lat_tick   <= '0;
      walking    <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      if (cfg_we) begin
        hcl <= cfg_wdata;
      end

      if (s_tvalid && s_tready) begin
        pend_valid <= 1'b1;
      end else if (pend_take) begin
        pend_valid <= 1'b0;
      end

      if (walk_start) begin
        walking <= 1'b1;
      end else if (walk_ack) begin
        walking <= 1'b0;
      end

      if (free_we) begin
        free_count <= free_count + CW'(1);
        free_na    <= pend_bound + TICK_W'(1);
      end
      if (rsv_we) begin
        rsv_count <= rsv_count + CW'(1);
        rsv_na    <= pend_bound;
      end

      // end of port: result leaves with the latch or the walk verdict, then the port resets
      if (out_load && out_done) begin
        free_count <= '0;
        rsv_count  <= '0;
        free_na    <= '0;
        rsv_na     <= '0;
        lat_err    <= ST_OK;
        lat_slot   <= '0;
        lat_tick   <= '0;
        cur_port   <= cur_port + PORT_W'(1);
      end else begin
        lat_err  <= err_next;
        lat_slot <= slot_next;
        lat_tick <= tick_next;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tlast  <= out_done;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pend_cmd   <= s_tuser;
      pend_start <= s_tdata[START_W-1:0];
      pend_bound <= s_tdata[START_W+TICK_W-1:START_W];
    end
    if (out_load) begin
      out_status <= err_next;
      out_port   <= cur_port;
      out_slot   <= slot_next;
      out_tick   <= tick_next;
    end
  end

  assign m_tdata = {{(M_DATA_W - STATUS_W - PORT_W - SLOT_W - TICK_W){1'b0}},
                    out_tick, out_slot, out_port, out_status};

  eslc_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_count[AW-1:0]),
    .wdata ({pend_bound[START_W-1:0], pend_start}),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  eslc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_SLOTS)
  ) u_rsv_ram (
    .clk   (clk),
    .we    (rsv_we),
    .waddr (rsv_count[AW-1:0]),
    .wdata ({pend_bound, pend_start}),
    .raddr (rsv_raddr),
    .rdata (rsv_rdata)
  );

  eslc_walk #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .ack        (walk_ack),
    .hcl        (hcl),
    .free_count (free_count),
    .rsv_count  (rsv_count),
    .free_rdata (free_rdata),
    .rsv_rdata  (rsv_rdata),
    .free_raddr (free_raddr),
    .rsv_raddr  (rsv_raddr),
    .res        (walk_res)
  );

`ifndef SYNTH
  a_walk_res_while_walking: assert property (@(posedge clk) disable iff (rst)
    walk_res.valid |-> walking)
    else $error("walk result without a walk in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (free_count <= CW'(MAX_SLOTS)) && (rsv_count <= CW'(MAX_SLOTS)))
    else $error("slot count beyond list depth");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    out_load && out_done |=> lat_err == ST_OK && free_count == '0 && rsv_count == '0)
    else $error("port state not cleared after end of port");

  a_walk_fail_status: assert property (@(posedge clk) disable iff (rst)
    walk_ack && walk_res.fail |=> m_tvalid && m_tlast && out_status == ST_NOT_INVERSE)
    else $error("failed walk not reported as not inverse");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    walking |-> !free_we && !rsv_we)
    else $error("slot memory written during walk");
`endif

endmodule
`default_nettype wire

// ----- verif/egress_slot_list_checker_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// egress_slot_list_checker_core_tb
// self-checking bench for the egress slot list checker
// ----------------------------------------------------------------------------
// every accepted slot item is run through a local predictor of the port
// checks (per-slot checks on arrival, tiling walk at end of port) and the
// expected verdict is queued. every result item is compared field by field
// with the oldest queued verdict. directed ports cover each error code, the
// free-first tie in the walk and the hyper cycle extremes, full lists fill
// both memories, and the random part sends mostly well-formed port tilings
// with some broken slots and noise, under random idling and back pressure.
// ----------------------------------------------------------------------------
module egress_slot_list_checker_core_tb;
  import eslc_pkg::*;

  localparam int                  SLOT_CAP   = MAX_SLOTS_DEF;
  localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;   // reported but changes nothing in the block
  localparam logic [HCL_W-1:0]    HCL_MAX    = 32'hFFFF_FFFF;
  localparam int                  LONG_HOLD  = 300;
  localparam int                  RUN_LIMIT  = 5_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [START_W-1:0] start;
    logic [TICK_W-1:0]  bound;
  } slot_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   port;
    logic [SLOT_W-1:0]   slot;
    logic [TICK_W-1:0]   tick;
    logic                done;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [HCL_W-1:0]     cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;   // start_tick, bound_tick
  logic [CMD_W-1:0]     s_tuser;   // command
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;   // status, port_number, failing_slot, failing_tick
  logic                 m_tlast;   // port_done

  egress_slot_list_checker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state, reset values
  // --------------------------------------------------------------------------
  logic [HCL_W-1:0]    hyper_len = 1;
  logic [START_W-1:0]  free_start_mem [SLOT_CAP];
  logic [START_W-1:0]  free_last_mem  [SLOT_CAP];
  logic [START_W-1:0]  rsv_start_mem  [SLOT_CAP];
  logic [TICK_W-1:0]   rsv_end_mem    [SLOT_CAP];
  int                  free_cnt  = 0;
  int                  rsv_cnt   = 0;
  logic [TICK_W-1:0]   free_next = '0;
  logic [TICK_W-1:0]   rsv_next  = '0;
  logic [PORT_W-1:0]   cur_port  = '0;
  logic [STATUS_W-1:0] lat_status = ST_OK;
  logic [SLOT_W-1:0]   lat_slot  = '0;
  logic [TICK_W-1:0]   lat_tick  = '0;

  verdict_t verdict_q [$];   // verdicts of accepted items, oldest first
  int       fail_count   = 0;
  int       items_sent   = 0;
  bit       tx_idle_on   = 1'b1;
  bit       rx_idle_on   = 1'b1;
  int       rx_hold_cycles = 0;

  // first error of the port sticks
  function automatic void latch(logic [STATUS_W-1:0] code, int slot, logic [TICK_W-1:0] tick);
    lat_status = code;
    lat_slot   = slot[SLOT_W-1:0];
    lat_tick   = tick;
  endfunction

  function automatic void take_free(logic [START_W-1:0] start, logic [TICK_W-1:0] last);
    if ({1'b0, start} > last)
      latch(ST_FREE_SHORT, free_cnt, {1'b0, start});
    else if ({1'b0, start} < free_next)
      latch(ST_FREE_UNSORT, free_cnt, {1'b0, start});
    else if ({1'b0, start} == free_next && free_next != '0)
      latch(ST_FREE_UNMERGE, free_cnt, {1'b0, start});
    else if (last >= {1'b0, hyper_len})
      latch(ST_FREE_BORDER, free_cnt, last);
    else if (free_cnt >= SLOT_CAP)
      latch(ST_LIST_FULL, free_cnt, {1'b0, start});
    else begin
      free_start_mem[free_cnt] = start;
      free_last_mem[free_cnt]  = last[START_W-1:0];
      free_cnt++;
      free_next = last + 33'd1;
    end
  endfunction

  function automatic void take_reserved(logic [START_W-1:0] start, logic [TICK_W-1:0] stop);
    if ({1'b0, start} >= stop)
      latch(ST_RSV_SHORT, rsv_cnt, {1'b0, start});
    else if ({1'b0, start} < rsv_next)
      latch(ST_RSV_UNSORT, rsv_cnt, {1'b0, start});
    else if (stop > {1'b0, hyper_len})
      latch(ST_RSV_BORDER, rsv_cnt, stop - 33'd1);
    else if (rsv_cnt >= SLOT_CAP)
      latch(ST_LIST_FULL, rsv_cnt, {1'b0, start});
    else begin
      rsv_start_mem[rsv_cnt] = start;
      rsv_end_mem[rsv_cnt]   = stop;
      rsv_cnt++;
      rsv_next = stop;
    end
  endfunction

  // two cursors from tick 0; a free slot wins when both start at the tick
  function automatic void walk_tiling();
    logic [TICK_W-1:0] tick;
    int fc;
    int rc;
    tick = '0;
    fc = 0;
    rc = 0;
    while (tick != {1'b0, hyper_len}) begin
      if (fc < free_cnt && {1'b0, free_start_mem[fc]} == tick) begin
        tick = {1'b0, free_last_mem[fc]} + 33'd1;
        fc++;
      end else if (rc < rsv_cnt && {1'b0, rsv_start_mem[rc]} == tick) begin
        tick = rsv_end_mem[rc];
        rc++;
      end else begin
        latch(ST_NOT_INVERSE, 0, tick);
        return;
      end
    end
  endfunction

  // verdict reported for one accepted item, state advanced past it
  function automatic verdict_t predict_verdict(slot_item_t item);
    verdict_t v;
    logic     done;
    done = 1'b0;
    if (item.cmd == CMD_FREE && lat_status == ST_OK)
      take_free(item.start, item.bound);
    else if (item.cmd == CMD_RSV && lat_status == ST_OK)
      take_reserved(item.start, item.bound);
    else if (item.cmd == CMD_END) begin
      if (lat_status == ST_OK)
        walk_tiling();
      done = 1'b1;
    end
    v = '{lat_status, cur_port, lat_slot, lat_tick, done};
    if (done) begin
      free_cnt   = 0;
      rsv_cnt    = 0;
      free_next  = '0;
      rsv_next   = '0;
      lat_status = ST_OK;
      lat_slot   = '0;
      lat_tick   = '0;
      cur_port   = cur_port + 16'd1;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // result side: tready with random holds, long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int pause;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        pause = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        pause = rx_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (pause != 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  function automatic void compare_field(string name, logic [TICK_W-1:0] want,
                                        logic [TICK_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // every accepted result against the oldest verdict
  always @(posedge clk) begin : result_check
    verdict_t want;
    verdict_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.status = m_tdata[3:0];
      got.port   = m_tdata[19:4];
      got.slot   = m_tdata[28:20];
      got.tick   = m_tdata[61:29];
      got.done   = m_tlast;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        compare_field("status", TICK_W'(want.status), TICK_W'(got.status));
        compare_field("port_number", TICK_W'(want.port), TICK_W'(got.port));
        compare_field("failing_slot", TICK_W'(want.slot), TICK_W'(got.slot));
        compare_field("failing_tick", want.tick, got.tick);
        compare_field("port_done", TICK_W'(want.done), TICK_W'(got.done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // slot side
  // --------------------------------------------------------------------------
  // entered and left on a falling edge; tvalid stays up for a back-to-back item
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [START_W-1:0] start,
                           logic [TICK_W-1:0] bound);
    int gap;
    slot_item_t item;
    item = '{cmd, start, bound};
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, bound, start};
    do @(posedge clk); while (s_tready !== 1'b1);
    verdict_q.push_back(predict_verdict(item));
    items_sent++;
    @(negedge clk);
  endtask

  // sender quiet until every verdict has come back, then a short tail
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic set_hyper_cycle(logic [HCL_W-1:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    hyper_len = value;
  endtask

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  // any command, any start, bound with bit 32 either way
  function automatic slot_item_t random_noise_item();
    slot_item_t item;
    item.cmd   = CMD_W'($urandom_range(0, 3));
    item.start = $urandom;
    item.bound = {1'($urandom_range(0, 1)), 32'($urandom)};
    return item;
  endfunction

  // one port: a random tiling of the hyper cycle, sometimes broken or noisy
  task automatic run_random_port();
    slot_item_t free_list [$];
    slot_item_t rsv_list [$];
    slot_item_t items [$];
    longint unsigned t, room, cap, len, hcl64;
    int n, k, pos;
    bit prev_free, as_free;
    hcl64 = 64'(hyper_len);
    n = $urandom_range(1, 12);
    if (hcl64 < n)
      n = int'(hcl64);
    t = 0;
    prev_free = 1'b0;
    for (k = 0; k < n; k++) begin
      // leave at least one tick for every later segment
      room = hcl64 - t - (n - 1 - k);
      if (k == n - 1)
        len = hcl64 - t;
      else begin
        cap = 2 * (room / (n - k));
        if (cap == 0)
          cap = 1;
        len = 1 + rand64() % cap;
        if (len > room)
          len = room;
      end
      // two free slots never touch
      as_free = !prev_free && $urandom_range(0, 1);
      if (as_free)
        free_list.push_back('{CMD_FREE, t[31:0], 33'(t + len - 1)});
      else
        rsv_list.push_back('{CMD_RSV, t[31:0], 33'(t + len)});
      prev_free = as_free;
      t += len;
    end
    // the two lists are independent, so mix them in any order
    while (free_list.size() + rsv_list.size() != 0) begin
      if (rsv_list.size() == 0 || (free_list.size() != 0 && $urandom_range(0, 1)))
        items.push_back(free_list.pop_front());
      else
        items.push_back(rsv_list.pop_front());
    end
    if (items.size() == 0) begin
      repeat ($urandom_range(0, 3)) items.push_back(random_noise_item());
    end else if ($urandom_range(0, 9) < 4) begin
      pos = $urandom_range(0, items.size() - 1);
      case ($urandom_range(0, 4))
        0: items.delete(pos);
        1: items[pos].start = items[pos].start + $urandom_range(0, 2) - 1;
        2: items[pos].bound = items[pos].bound + $urandom_range(0, 2) - 1;
        3: items.insert(pos, items[pos]);
        default: items.insert(pos, random_noise_item());
      endcase
    end
    foreach (items[i])
      send_item(items[i].cmd, items[i].start, items[i].bound);
    // payload of an end of port item is ignored, so fill it randomly
    send_item(CMD_END, $urandom, {1'($urandom_range(0, 1)), 32'($urandom)});
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // every error code but list full, the free-first tie and a gap in the tiling
  task automatic test_slot_checks();
    set_hyper_cycle(32'd10);
    send_item(CMD_END, 32'd0, 33'd0);            // empty port leaves tick 0 open
    send_item(CMD_FREE, 32'd0, 33'd2);
    send_item(CMD_RSV, 32'd3, 33'd6);
    send_item(CMD_UNUSED, 32'd7, 33'd1);         // ignored item mid port
    send_item(CMD_FREE, 32'd6, 33'd9);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, 32'd5, 33'd4);           // free too short
    send_item(CMD_FREE, 32'd0, 33'd1);           // dropped after the error
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, 32'd4, 33'd5);
    send_item(CMD_FREE, 32'd2, 33'd3);           // free out of order
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, 32'd0, 33'd3);
    send_item(CMD_FREE, 32'd4, 33'd6);           // free touching previous free
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, 32'd8, 33'd10);          // free past the border
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd3, 33'd3);            // reserved empty
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd0, 33'd5);
    send_item(CMD_RSV, 32'd4, 33'd8);            // reserved overlap
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd5, 33'd11);           // reserved past the border
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, 32'd0, 33'd9);           // both lists start at 0
    send_item(CMD_RSV, 32'd0, 33'd10);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd0, 33'd4);
    send_item(CMD_FREE, 32'd5, 33'd9);           // tick 4 uncovered
    send_item(CMD_END, 32'd0, 33'd0);
  endtask

  // zero, one and the largest hyper cycle, widest field values
  task automatic test_cycle_extremes();
    set_hyper_cycle(32'd0);
    send_item(CMD_END, 32'd0, 33'd0);            // nothing to tile
    send_item(CMD_FREE, 32'd0, 33'd0);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd0, 33'd1);
    send_item(CMD_END, 32'd0, 33'd0);
    set_hyper_cycle(HCL_MAX);
    send_item(CMD_FREE, 32'd0, 33'h0_FFFF_FFFE);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, 32'd0, 33'h0_FFFF_FFFF);
    send_item(CMD_END, HCL_MAX, 33'h1_FFFF_FFFF);
    send_item(CMD_RSV, 32'd0, 33'h1_0000_0000);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_FREE, HCL_MAX, 33'h1_FFFF_FFFF);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, HCL_MAX, 33'h1_FFFF_FFFF);
    send_item(CMD_END, 32'd0, 33'd0);
    send_item(CMD_RSV, HCL_MAX, 33'd0);
    send_item(CMD_END, 32'd0, 33'd0);
    set_hyper_cycle(32'd1);
    send_item(CMD_FREE, 32'd0, 33'd0);
    send_item(CMD_END, 32'd0, 33'd0);
  endtask

  // one slot past capacity in each list, and a tiling of exactly capacity
  task automatic test_list_full();
    set_hyper_cycle(HCL_MAX);
    for (int k = 0; k <= SLOT_CAP; k++)
      send_item(CMD_FREE, 32'(2 * k), 33'(2 * k));
    send_item(CMD_END, 32'd0, 33'd0);
    for (int k = 0; k <= SLOT_CAP; k++)
      send_item(CMD_RSV, 32'(k), 33'(k + 1));
    send_item(CMD_END, 32'd0, 33'd0);
    set_hyper_cycle(32'(SLOT_CAP));
    for (int k = 0; k < SLOT_CAP; k++)
      send_item(CMD_RSV, 32'(k), 33'(k + 1));
    send_item(CMD_END, 32'd0, 33'd0);
  endtask

  // result side stalls long while items keep coming, then takes results without pauses
  task automatic test_back_pressure();
    set_hyper_cycle(32'd30);
    tx_idle_on = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    repeat (4) run_random_port();
    wait_drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    repeat (2) run_random_port();
    wait_drain();
    rx_idle_on = 1'b1;
  endtask

  // random ports over a series of hyper cycle settings
  task automatic test_random_ports(int budget);
    int stop_at;
    int chunk_end;
    logic [HCL_W-1:0] hcl;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 6))
        0: hcl = $urandom_range(1, 40);
        1: hcl = $urandom_range(41, 100000);
        2: hcl = $urandom;
        3: hcl = HCL_MAX;
        4: hcl = 32'd0;
        default: hcl = $urandom_range(1, 12);
      endcase
      set_hyper_cycle(hcl);
      chunk_end = items_sent + ((hcl == 0) ? 20 : 100);
      while (items_sent < chunk_end) begin
        tx_idle_on = ($urandom_range(0, 9) != 0);
        rx_idle_on = ($urandom_range(0, 9) != 0);
        run_random_port();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_FREE;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_slot_checks();
    test_cycle_extremes();
    test_list_full();
    test_back_pressure();
    test_random_ports(900);
    wait_drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
